FILE: rtl/core/iuk_pkg.sv
`default_nettype none
package iuk_pkg;

	localparam int MAX_RANGES = 64;
	localparam int CNT_W = $clog2(2 * MAX_RANGES);
	localparam int NUM_W = $clog2(MAX_RANGES + 1);

	localparam logic [1:0] REQ_CLEAR = 2'd0;
	localparam logic [1:0] REQ_ADD = 2'd1;
	localparam logic [1:0] REQ_QUERY = 2'd2;

	typedef struct packed {
		logic [1:0] req_type;
		logic signed [31:0] range_low;
		logic signed [31:0] range_high;
		logic [37:0] query_rank;
	} iuk_in_t;

	typedef struct packed {
		logic signed [31:0] kth_value;
		logic found;
		logic overflow;
	} iuk_out_t;

	typedef struct packed {
		logic v;
		logic signed [31:0] lo;
		logic signed [31:0] hi;
	} entry_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_SHIFT,
		CELL_PACK,
		CELL_CLEAR
	} cell_mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROT,
		ST_PACK,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic [NUM_W-1:0] n_out;
		logic pend;
		logic hit;
		logic signed [31:0] value;
	} head_stat_t;

endpackage
`default_nettype wire

FILE: rtl/core/iuk_cell.sv
`default_nettype none
module iuk_cell (
	input wire logic clk,
	input wire logic arst_n,
	input wire iuk_pkg::cell_mode_t mode,
	input wire iuk_pkg::entry_t right,
	input wire logic left_v,
	output iuk_pkg::entry_t q
);
	import iuk_pkg::*;

	logic v_q;
	logic signed [31:0] lo_q;
	logic signed [31:0] hi_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else begin
			case (mode)
				CELL_SHIFT: v_q <= right.v;
				// A hole pulls in its right neighbor; a word that moved left leaves a hole.
				CELL_PACK: begin
					if (!v_q) v_q <= right.v;
					else if (!left_v) v_q <= 1'b0;
				end
				CELL_CLEAR: v_q <= 1'b0;
				default: v_q <= v_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mode == CELL_SHIFT || (mode == CELL_PACK && !v_q)) begin
			lo_q <= right.lo;
			hi_q <= right.hi;
		end
	end

	assign q = '{v: v_q, lo: lo_q, hi: hi_q};
endmodule
`default_nettype wire

FILE: rtl/core/iuk_head.sv
`default_nettype none
module iuk_head (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic step,
	input wire logic take,
	input wire logic last,
	input wire logic is_add,
	input wire logic full,
	input wire logic signed [31:0] lo,
	input wire logic signed [31:0] hi,
	input wire logic [37:0] rank,
	input wire iuk_pkg::entry_t e_in,
	output iuk_pkg::entry_t e_out,
	output iuk_pkg::entry_t held,
	output iuk_pkg::head_stat_t stat
);
	import iuk_pkg::*;

	logic add_q, pend_q, hit_q, merged_q, hold_v_q;
	logic [NUM_W-1:0] nout_q;
	logic signed [31:0] lo_q, hi_q, mlo_q, mhi_q, val_q, hold_lo_q, hold_hi_q;
	logic [37:0] left_q;

	logic pend_d, hit_d, merged_d;
	logic signed [31:0] mlo_d, mhi_d, val_d;
	entry_t hold_e, hold_d, m_e;
	logic [37:0] left_d, len;
	logic [32:0] diff;

	assign hold_e = '{v: hold_v_q, lo: hold_lo_q, hi: hold_hi_q};

	always_comb begin
		e_out = e_in;
		pend_d = pend_q;
		merged_d = merged_q;
		hold_d = hold_e;
		mlo_d = mlo_q;
		mhi_d = mhi_q;
		hit_d = hit_q;
		val_d = val_q;
		left_d = left_q;
		m_e = '{v: 1'b1, lo: mlo_q, hi: mhi_q};
		diff = {e_in.hi[31], e_in.hi} - {e_in.lo[31], e_in.lo};
		len = 38'(diff) + 38'd1;
		if (add_q) begin
			if (!e_in.v) begin
				if (hold_e.v) begin
					e_out = hold_e;
					hold_d.v = 1'b0;
				end else if (pend_q) begin
					e_out = m_e;
					pend_d = 1'b0;
				end
			end else if (e_in.hi < lo_q) begin
				e_out = e_in;
			end else if (e_in.lo <= hi_q) begin
				mlo_d = (e_in.lo < mlo_q) ? e_in.lo : mlo_q;
				mhi_d = (e_in.hi > mhi_q) ? e_in.hi : mhi_q;
				merged_d = 1'b1;
				e_out.v = 1'b0;
				// A merge that runs to the end of a full table lands in the last slot.
				if (last) begin
					e_out = '{v: 1'b1, lo: mlo_d, hi: mhi_d};
					pend_d = 1'b0;
				end
			end else if (pend_q) begin
				// A full table only has room when the new range swallowed a stored one;
				// the last stored range then stays in the hold until packing.
				if (!full || merged_q) begin
					e_out = m_e;
					pend_d = 1'b0;
					hold_d = e_in;
				end
			end else if (hold_e.v) begin
				e_out = hold_e;
				hold_d = e_in;
			end
		end else if (e_in.v && !hit_q && left_q != '0) begin
			if (left_q <= len) begin
				val_d = e_in.lo + left_q[31:0] - 32'sd1;
				hit_d = 1'b1;
			end else begin
				left_d = left_q - len;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			add_q <= 1'b0;
			pend_q <= 1'b0;
			hit_q <= 1'b0;
			merged_q <= 1'b0;
			nout_q <= '0;
			hold_v_q <= 1'b0;
		end else if (start) begin
			add_q <= is_add;
			pend_q <= 1'b1;
			hit_q <= 1'b0;
			merged_q <= 1'b0;
			nout_q <= '0;
			hold_v_q <= 1'b0;
		end else if (step) begin
			pend_q <= pend_d;
			hit_q <= hit_d;
			merged_q <= merged_d;
			nout_q <= nout_q + NUM_W'(e_out.v);
			hold_v_q <= hold_d.v;
		end else if (take && hold_v_q) begin
			hold_v_q <= 1'b0;
			nout_q <= nout_q + NUM_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			lo_q <= lo;
			hi_q <= hi;
			mlo_q <= lo;
			mhi_q <= hi;
			left_q <= rank;
			val_q <= '0;
		end else if (step) begin
			mlo_q <= mlo_d;
			mhi_q <= mhi_d;
			left_q <= left_d;
			val_q <= val_d;
			hold_lo_q <= hold_d.lo;
			hold_hi_q <= hold_d.hi;
		end
	end

	assign held = hold_e;
	assign stat = '{n_out: nout_q, pend: pend_q, hit: hit_q, value: val_q};
endmodule
`default_nettype wire

FILE: rtl/core/interval_union_kth_smallest.sv
`default_nettype none
// Keeps up to MAX_RANGES disjoint ranges in a chain of cells, one range per cell,
// sorted by lower end. A query rotates the whole chain once through the head unit,
// which counts ranks, and then offers its result word. An add also rotates the
// chain once while the head merges the new range in, then packs the chain to close
// the holes left by fused ranges. A clear, an empty range or an unused request
// code is finished in the idle state. One item is worked on at a time.
module interval_union_kth_smallest (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire iuk_pkg::iuk_in_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output iuk_pkg::iuk_out_t out_data
);
	import iuk_pkg::*;

	state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] count_q;
	logic dropped_q, out_valid_q, is_add_q;
	iuk_out_t out_q;

	cell_mode_t mode;
	entry_t cell_q [MAX_RANGES];
	entry_t head_out, head_held, last_in;
	head_stat_t hstat;
	logic accept, start, step, take, last_rot, last_pack, resp_go;

	assign accept = in_valid && in_ready;
	assign last_rot = cnt_q == CNT_W'(MAX_RANGES - 1);
	assign last_pack = cnt_q == CNT_W'(2 * MAX_RANGES - 1);
	assign resp_go = !out_valid_q || out_ready;
	assign take = mode == CELL_PACK && !cell_q[MAX_RANGES - 1].v;

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		start = 1'b0;
		step = 1'b0;
		mode = CELL_HOLD;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_data.req_type == REQ_CLEAR) begin
						mode = CELL_CLEAR;
					end else if ((in_data.req_type == REQ_ADD
							&& in_data.range_low <= in_data.range_high)
							|| in_data.req_type == REQ_QUERY) begin
						start = 1'b1;
						state_d = ST_ROT;
					end
				end
			end
			ST_ROT: begin
				step = 1'b1;
				mode = CELL_SHIFT;
				if (last_rot) state_d = is_add_q ? ST_PACK : ST_RESP;
			end
			ST_PACK: begin
				mode = CELL_PACK;
				if (last_pack) state_d = ST_IDLE;
			end
			ST_RESP: begin
				if (resp_go) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			count_q <= '0;
			dropped_q <= 1'b0;
			out_valid_q <= 1'b0;
			is_add_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q != state_d) cnt_q <= '0;
			else cnt_q <= cnt_q + CNT_W'(1);
			if (start) is_add_q <= in_data.req_type == REQ_ADD;
			if (accept && in_data.req_type == REQ_CLEAR) begin
				count_q <= '0;
				dropped_q <= 1'b0;
			end
			if (state_q == ST_PACK && last_pack) begin
				count_q <= hstat.n_out;
				if (hstat.pend) dropped_q <= 1'b1;
			end
			if (state_q == ST_RESP && resp_go) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RESP && resp_go) begin
			out_q <= '{kth_value: hstat.value, found: hstat.hit, overflow: dropped_q};
		end
	end

	iuk_head u_head (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.step(step),
		.take(take),
		.last(last_rot),
		.is_add(in_data.req_type == REQ_ADD),
		.full(count_q == NUM_W'(MAX_RANGES)),
		.lo(in_data.range_low),
		.hi(in_data.range_high),
		.rank(in_data.query_rank),
		.e_in(cell_q[0]),
		.e_out(head_out),
		.held(head_held),
		.stat(hstat)
	);

	// During a rotation the head's word enters at the tail; while packing, a range
	// still held by the head enters there once the tail cell is free.
	always_comb begin
		last_in = head_out;
		if (mode == CELL_PACK) last_in = head_held;
		else if (mode != CELL_SHIFT) last_in.v = 1'b0;
	end

	for (genvar i = 0; i < MAX_RANGES; i++) begin : g_cell
		iuk_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.mode(mode),
			.right(i == MAX_RANGES - 1 ? last_in : cell_q[(i + 1) % MAX_RANGES]),
			.left_v(i == 0 ? 1'b1 : cell_q[(i + MAX_RANGES - 1) % MAX_RANGES].v),
			.q(cell_q[i])
		);
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;
endmodule
`default_nettype wire
